// ===== hw/rtl/msbs_pkg.sv =====
// Shared types and constants for the bulk-only mass-storage engine.
// No dependencies; used by mass_storage_bulk_scsi_engine.
package msbs_pkg;

   // Event codes on the request channel
   localparam logic [1:0] CMD_CBW      = 2'd0;
   localparam logic [1:0] CMD_OUT_DATA = 2'd1;
   localparam logic [1:0] CMD_IN_DONE  = 2'd2;

   // Result actions
   localparam logic [2:0] ACT_STATUS      = 3'd0;
   localparam logic [2:0] ACT_SECTOR      = 3'd1;
   localparam logic [2:0] ACT_ZERO_FILL   = 3'd2;
   localparam logic [2:0] ACT_INQUIRY     = 3'd3;
   localparam logic [2:0] ACT_CAPACITY    = 3'd4;
   localparam logic [2:0] ACT_FORMAT_CAP  = 3'd5;
   localparam logic [2:0] ACT_WRITE_FRAG  = 3'd6;

   // SCSI operation codes
   localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
   localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
   localparam logic [7:0] OP_INQUIRY         = 8'h12;
   localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
   localparam logic [7:0] OP_READ10          = 8'h28;
   localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
   localparam logic [7:0] OP_WRITE10         = 8'h2A;
   localparam logic [7:0] OP_MODE_SENSE10    = 8'h5A;
   localparam logic [7:0] OP_MEDIUM_REMOVAL  = 8'h1E;
   localparam logic [7:0] OP_READ_FMT_CAP    = 8'h23;

   // Wrapper constants
   localparam logic [31:0] CBW_SIGNATURE = 32'h43425355;
   localparam logic [15:0] CSW_BYTES     = 16'd13;
   localparam logic [15:0] INQUIRY_MIN   = 16'd36;
   localparam logic [15:0] CAPACITY_BYTES = 16'd8;
   localparam logic [15:0] FMT_CAP_BYTES  = 16'd12;

   // Configuration register indexes
   localparam logic [1:0] CSR_BULK_ENDPOINT = 2'd0;
   localparam logic [1:0] CSR_SECTOR_SIZE   = 2'd1;
   localparam logic [1:0] CSR_SECTOR_COUNT  = 2'd2;

   // Result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  endpoint;
      logic [31:0] cbw_signature;
      logic [31:0] cbw_tag;
      logic [7:0]  scsi_opcode;
      logic [31:0] block_address;
      logic [15:0] transfer_length;
      logic [15:0] allocation_length;
      logic [7:0]  subpage_code;
      logic [9:0]  fragment_length;
      logic        endpoint_idle;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sector_address;
      logic [11:0] byte_offset;
      logic [15:0] byte_count;
      logic [31:0] capacity_value;
      logic [31:0] csw_tag;
      logic        csw_status;
      logic        last;
   } rsp_type;

endpackage

// ===== hw/rtl/mass_storage_bulk_scsi_engine.sv =====
// Bulk-only mass-storage engine: event decode, transfer state and result queue.
// Depends on msbs_pkg for the payload structs, action and opcode codes.
//
// The engine takes one event word per cycle on the req_ channel while
// req_stall is low. An accepted word is held in an input register and decoded
// against the transfer state from there, and its results (none, one or two)
// enter an 8-entry result queue that drives the rsp_ channel, so a result
// passes through the input register and the queue before it appears. Results
// leave at one per cycle while rsp_stall is low; an OUT fragment that
// completes the final sector of a write yields a fragment and a status word,
// so it puts two words into the queue for the single result port. req_stall
// rises when fewer than four queue slots are free. csr_ready is always high;
// registers may be written only while no event is in flight.
module mass_storage_bulk_scsi_engine #(
   parameter int MAX_SECTOR_BYTES = 4096,
   parameter int PACKET_BYTES     = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  msbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output msbs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_RESPOND = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;
   localparam logic [1:0] MODE_WRITE   = 2'd3;

   localparam int RSP_CNT_W_L = msbs_pkg::RSP_CNT_W;
   localparam logic [31:0] MAX_SECTOR_32 = 32'(MAX_SECTOR_BYTES);
   localparam logic [12:0] PACKET_13     = 13'(PACKET_BYTES);
   localparam logic [RSP_CNT_W_L-1:0] STALL_LEVEL = RSP_CNT_W_L'(msbs_pkg::RSP_DEPTH - 4);

   // Configuration registers
   logic [3:0]  bulk_ep_ff;
   logic [12:0] sector_size_ff;
   logic [31:0] sector_count_ff;

   // Transfer state
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] next_sector_ff, next_sector_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [12:0] frag_off_ff, frag_off_in;
   logic [31:0] pend_tag_ff, pend_tag_in;
   logic        pend_status_ff, pend_status_in;

   // Input register
   logic              in_valid_ff;
   msbs_pkg::req_type in_ff;

   // Result queue
   msbs_pkg::rsp_type rsp_mem [msbs_pkg::RSP_DEPTH];
   logic [msbs_pkg::RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W_L-1:0]         count_ff;

   // Decode results
   msbs_pkg::rsp_type res0, res1;
   logic [1:0]  push_n;
   logic [12:0] eff_ss;
   logic [12:0] frag_n, room, off_new;
   logic [13:0] off_sum;
   logic [15:0] rem_dec;

   logic req_accept, rsp_accept;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > STALL_LEVEL;
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = rsp_mem[rd_ptr_ff];
   assign csr_ready  = 1'b1;

   // Configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bulk_ep_ff      <= 4'd1;
         sector_size_ff  <= 13'd512;
         sector_count_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            msbs_pkg::CSR_BULK_ENDPOINT: bulk_ep_ff      <= csr_data[3:0];
            msbs_pkg::CSR_SECTOR_SIZE:   sector_size_ff  <= csr_data[12:0];
            msbs_pkg::CSR_SECTOR_COUNT:  sector_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective sector size: clamp to the maximum, zero counts as one byte
   always_comb begin
      eff_ss = sector_size_ff;
      if ({19'd0, sector_size_ff} > MAX_SECTOR_32) eff_ss = MAX_SECTOR_32[12:0];
      if (eff_ss == 13'd0) eff_ss = 13'd1;
   end

   // Fragment length limited by packet size and room left in the sector
   always_comb begin
      room    = (frag_off_ff < eff_ss) ? eff_ss - frag_off_ff : 13'd0;
      frag_n  = {3'd0, in_ff.fragment_length};
      if (frag_n > PACKET_13) frag_n = PACKET_13;
      if (frag_n > room) frag_n = room;
      off_sum = {1'b0, frag_off_ff} + {1'b0, frag_n};
      off_new = off_sum[12:0];
      rem_dec = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : 16'd0;
   end

   // Event decode
   always_comb begin
      mode_in        = mode_ff;
      next_sector_in = next_sector_ff;
      remaining_in   = remaining_ff;
      frag_off_in    = frag_off_ff;
      pend_tag_in    = pend_tag_ff;
      pend_status_in = pend_status_ff;
      res0           = '0;
      res1           = '0;
      res0.last      = 1'b1;
      res1.last      = 1'b1;
      push_n         = 2'd0;

      if (in_valid_ff && in_ff.endpoint == bulk_ep_ff) begin
         case (in_ff.command)
            msbs_pkg::CMD_CBW: begin
               if (mode_ff == MODE_IDLE && in_ff.cbw_signature == msbs_pkg::CBW_SIGNATURE) begin
                  pend_tag_in    = in_ff.cbw_tag;
                  pend_status_in = 1'b1;
                  unique case (in_ff.scsi_opcode) inside
                     msbs_pkg::OP_TEST_UNIT_READY, msbs_pkg::OP_MEDIUM_REMOVAL: begin
                        pend_status_in  = 1'b0;
                        mode_in         = MODE_IDLE;
                        res0.action     = msbs_pkg::ACT_STATUS;
                        res0.byte_count = msbs_pkg::CSW_BYTES;
                        res0.csw_tag    = in_ff.cbw_tag;
                        push_n          = 2'd1;
                     end
                     msbs_pkg::OP_REQUEST_SENSE, msbs_pkg::OP_MODE_SENSE10: begin
                        pend_status_in  = 1'b0;
                        mode_in         = MODE_RESPOND;
                        res0.action     = msbs_pkg::ACT_ZERO_FILL;
                        res0.byte_count = in_ff.allocation_length;
                        push_n          = 2'd1;
                     end
                     msbs_pkg::OP_INQUIRY: begin
                        // short inquiry: tag latched, nothing sent
                        if (in_ff.allocation_length >= msbs_pkg::INQUIRY_MIN) begin
                           pend_status_in  = 1'b0;
                           mode_in         = MODE_RESPOND;
                           res0.action     = msbs_pkg::ACT_INQUIRY;
                           res0.byte_count = in_ff.allocation_length;
                           push_n          = 2'd1;
                        end
                     end
                     msbs_pkg::OP_READ_CAPACITY: begin
                        pend_status_in      = 1'b0;
                        mode_in             = MODE_RESPOND;
                        res0.action         = msbs_pkg::ACT_CAPACITY;
                        res0.byte_count     = msbs_pkg::CAPACITY_BYTES;
                        res0.capacity_value = sector_count_ff - 32'd1;
                        push_n              = 2'd1;
                     end
                     msbs_pkg::OP_READ10: begin
                        next_sector_in      = in_ff.block_address + 32'd1;
                        remaining_in        = (in_ff.transfer_length == 16'd0) ? 16'd0 :
                                              in_ff.transfer_length - 16'd1;
                        mode_in             = MODE_READ;
                        pend_status_in      = 1'b0;
                        res0.action         = msbs_pkg::ACT_SECTOR;
                        res0.sector_address = in_ff.block_address;
                        res0.byte_count     = {3'd0, eff_ss};
                        push_n              = 2'd1;
                     end
                     msbs_pkg::OP_MODE_SENSE6: begin
                        pend_status_in = 1'b0;
                        mode_in        = MODE_RESPOND;
                        if (in_ff.subpage_code == 8'd0) begin
                           res0.action     = msbs_pkg::ACT_ZERO_FILL;
                           res0.byte_count = in_ff.allocation_length;
                           push_n          = 2'd1;
                        end
                     end
                     msbs_pkg::OP_WRITE10: begin
                        remaining_in   = in_ff.transfer_length;
                        next_sector_in = in_ff.block_address;
                        frag_off_in    = 13'd0;
                        mode_in        = MODE_WRITE;
                        pend_status_in = 1'b0;
                     end
                     msbs_pkg::OP_READ_FMT_CAP: begin
                        pend_status_in      = 1'b0;
                        mode_in             = MODE_RESPOND;
                        res0.action         = msbs_pkg::ACT_FORMAT_CAP;
                        res0.byte_count     = msbs_pkg::FMT_CAP_BYTES;
                        res0.capacity_value = sector_count_ff;
                        push_n              = 2'd1;
                     end
                     default: begin
                        // unsupported opcode: failed status
                        mode_in         = MODE_IDLE;
                        res0.action     = msbs_pkg::ACT_STATUS;
                        res0.byte_count = msbs_pkg::CSW_BYTES;
                        res0.csw_tag    = in_ff.cbw_tag;
                        res0.csw_status = 1'b1;
                        push_n          = 2'd1;
                     end
                  endcase
               end
            end
            msbs_pkg::CMD_OUT_DATA: begin
               if (mode_ff == MODE_WRITE) begin
                  res0.action         = msbs_pkg::ACT_WRITE_FRAG;
                  res0.sector_address = next_sector_ff;
                  res0.byte_offset    = frag_off_ff[11:0];
                  res0.byte_count     = {3'd0, frag_n};
                  push_n              = 2'd1;
                  frag_off_in         = off_new;
                  if (off_new >= eff_ss) begin
                     // sector complete
                     next_sector_in = next_sector_ff + 32'd1;
                     remaining_in   = rem_dec;
                     frag_off_in    = 13'd0;
                     if (rem_dec == 16'd0) begin
                        mode_in         = MODE_IDLE;
                        res0.last       = 1'b0;
                        res1.action     = msbs_pkg::ACT_STATUS;
                        res1.byte_count = msbs_pkg::CSW_BYTES;
                        res1.csw_tag    = pend_tag_ff;
                        res1.csw_status = pend_status_ff;
                        push_n          = 2'd2;
                     end
                  end
               end
            end
            msbs_pkg::CMD_IN_DONE: begin
               if (in_ff.endpoint_idle) begin
                  if (mode_ff == MODE_READ && remaining_ff != 16'd0) begin
                     res0.action         = msbs_pkg::ACT_SECTOR;
                     res0.sector_address = next_sector_ff;
                     res0.byte_count     = {3'd0, eff_ss};
                     push_n              = 2'd1;
                     next_sector_in      = next_sector_ff + 32'd1;
                     remaining_in        = remaining_ff - 16'd1;
                  end else if (mode_ff == MODE_READ || mode_ff == MODE_RESPOND) begin
                     mode_in         = MODE_IDLE;
                     res0.action     = msbs_pkg::ACT_STATUS;
                     res0.byte_count = msbs_pkg::CSW_BYTES;
                     res0.csw_tag    = pend_tag_ff;
                     res0.csw_status = pend_status_ff;
                     push_n          = 2'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Input register and transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         mode_ff        <= MODE_IDLE;
         next_sector_ff <= 32'd0;
         remaining_ff   <= 16'd0;
         frag_off_ff    <= 13'd0;
         pend_tag_ff    <= 32'd0;
         pend_status_ff <= 1'b1;
      end else begin
         in_valid_ff    <= req_accept;
         mode_ff        <= mode_in;
         next_sector_ff <= next_sector_in;
         remaining_ff   <= remaining_in;
         frag_off_ff    <= frag_off_in;
         pend_tag_ff    <= pend_tag_in;
         pend_status_ff <= pend_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         rsp_mem[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         rsp_mem[wr_ptr_ff + msbs_pkg::RSP_PTR_W'(1)] <= res1;
      end
   end

   // Result queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + msbs_pkg::RSP_PTR_W'(push_n);
         if (rsp_accept) rd_ptr_ff <= rd_ptr_ff + msbs_pkg::RSP_PTR_W'(1);
         count_ff  <= count_ff + RSP_CNT_W_L'(push_n) - RSP_CNT_W_L'(rsp_accept);
      end
   end

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W_L'(msbs_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // Fill count grows by at most two words per cycle
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ({1'b0, count_ff} <= {1'b0, $past(count_ff)} + 2))
      else $error("result queue grew too fast");

   // With nothing queued and nothing decoding, no result can appear
   assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared without an event");

endmodule
